[design/ppc_pkg.sv]
// Package for the plasma pixel colour block: defaults, the square-root stage
// type, and the triangle wave and root-step functions. No dependencies.
package ppc_pkg;

  localparam int unsigned WIDTH_DEF  = 40;
  localparam int unsigned HEIGHT_DEF = 30;

  // Number of register stages from input acceptance to the output register.
  localparam int unsigned NUM_STAGES = 9;

  // Partial state of the digit-by-digit square root: remainder and root so far.
  typedef struct packed {
    logic [15:0] rem;
    logic [7:0]  root;
  } sqrt_t;

  // Triangle wave clamped to 0..255, already shifted right by 2.
  function automatic logic [5:0] wave_q(logic [7:0] k);
    logic [9:0] s;
    begin
      if (k < 8'd64) begin
        s = 10'd128 + {1'b0, k, 1'b0};
      end else if (k < 8'd192) begin
        s = 10'd384 - {1'b0, k, 1'b0};
      end else begin
        s = {1'b0, k, 1'b0} - 10'd384;
      end
      if (s > 10'd255) begin
        s = 10'd255;
      end
      return s[7:2];
    end
  endfunction

  // One bit of the restoring square root; root holds only bits above b.
  function automatic sqrt_t sqrt_step(sqrt_t s, int unsigned b);
    logic [16:0] trial;
    sqrt_t       r;
    begin
      trial = (17'(s.root) << (b + 1)) | (17'd1 << (2 * b));
      r     = s;
      if ({1'b0, s.rem} >= trial) begin
        r.rem  = 16'({1'b0, s.rem} - trial);
        r.root = s.root | (8'd1 << b);
      end
      return r;
    end
  endfunction

endpackage

[design/plasma_pixel_colour_top.sv]
// Plasma pixel colour: a nine-stage pipeline from pixel position and frame
// time to a 6-bit colour. Depends on ppc_pkg.
//
// Usage:
//  - Input channel: in_valid_i with column_i, row_i, frame_time_i; the block
//    takes a word at each rising edge where in_valid_i is high and
//    in_stall_o is low.
//  - Output channel: out_valid_o with colour_o; the receiver takes a word
//    at each edge where out_valid_o is high and out_stall_i is low.
//  - Throughput: one word per clock, sustained, while the receiver keeps up.
//  - Stage order: the radial term sets the pipeline length: abs, square,
//    sum, then a ceiling square root that resolves two root bits per stage
//    over four stages, then the final wave lookup and average.
//  - Stall: each stage advances when it is empty or the stage after it
//    advances, so bubbles collapse while the receiver stalls. in_stall_o
//    rises only when all nine stages hold words; the output word stays put
//    while stalled.
//  - Reset (rst_ni low, asynchronous): all stage valid bits clear; the data
//    registers are not reset. No configuration and no state across words.
//  - WIDTH and HEIGHT set the centre of the radial term (WIDTH/2, HEIGHT/2).
module plasma_pixel_colour_top #(
  parameter int unsigned WIDTH  = ppc_pkg::WIDTH_DEF,
  parameter int unsigned HEIGHT = ppc_pkg::HEIGHT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [5:0] column_i,
  input  logic [4:0] row_i,
  input  logic [7:0] frame_time_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] colour_o
);
  import ppc_pkg::*;

  localparam logic [8:0] CX = 9'(WIDTH / 2);
  localparam logic [8:0] CY = 9'(HEIGHT / 2);

  // stage valid bits and per-stage advance enables
  logic [NUM_STAGES:1] v_q;
  logic [NUM_STAGES:1] en;

  // stage 1: phases and absolute offsets from the centre
  logic [7:0]  p1_q, p2_q, p3_q;
  logic [7:0]  adx_q, ady_q;
  logic [8:0]  dx, dy;
  logic [7:0]  adx_d, ady_d;
  logic [7:0]  p1_d, p2_d, p3_d;
  // stage 2: squares and the sum of the three linear waves
  logic [15:0] sqx_q, sqy_q;
  logic [7:0]  wsum_d;
  // stages 3..7: square root state
  sqrt_t       sqrt_q [3:7];
  // frame time and wave sum carried alongside
  logic [7:0]  t_q    [1:7];
  logic [7:0]  wsum_q [2:8];
  // stage 8: radial phase
  logic [8:0]  ceil_d;
  logic [7:0]  p4_d, p4_q;
  // stage 9: output
  logic [7:0]  total_d;
  logic [5:0]  colour_q;

  always_comb begin
    en[NUM_STAGES] = !v_q[NUM_STAGES] || !out_stall_i;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 1 logic
  always_comb begin
    dx    = {3'b0, column_i} - CX;
    dy    = {4'b0, row_i} - CY;
    adx_d = dx[8] ? 8'(-dx) : dx[7:0];
    ady_d = dy[8] ? 8'(-dy) : dy[7:0];
    p1_d  = 8'({2'b0, column_i} * 8'd6) + frame_time_i;
    p2_d  = {row_i, 3'b0} + {frame_time_i[6:0], 1'b0};
    p3_d  = {8'({2'b0, column_i} + {3'b0, row_i})} ;
    p3_d  = {p3_d[5:0], 2'b0} + frame_time_i;
  end

  // stage 2 / 8 / 9 logic
  always_comb begin
    wsum_d  = 8'(wave_q(p1_q)) + 8'(wave_q(p2_q)) + 8'(wave_q(p3_q));
    ceil_d  = {1'b0, sqrt_q[7].root} + 9'(sqrt_q[7].rem != '0);
    p4_d    = {ceil_d[5:0], 2'b0} + {ceil_d[6:0], 1'b0} + t_q[7];
    total_d = wsum_q[8] + 8'(wave_q(p4_q));
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      p3_q   <= p3_d;
      adx_q  <= adx_d;
      ady_q  <= ady_d;
      t_q[1] <= frame_time_i;
    end
    if (en[2]) begin
      sqx_q     <= 16'(adx_q) * 16'(adx_q);
      sqy_q     <= 16'(ady_q) * 16'(ady_q);
      wsum_q[2] <= wsum_d;
    end
    if (en[3]) begin
      sqrt_q[3].rem  <= sqx_q + sqy_q;
      sqrt_q[3].root <= '0;
    end
    // two root bits per stage, most significant first
    for (int k = 4; k <= 7; k++) begin
      if (en[k]) begin
        sqrt_q[k] <= sqrt_step(sqrt_step(sqrt_q[k-1], 15 - 2 * k), 14 - 2 * k);
      end
    end
    for (int k = 2; k <= 7; k++) begin
      if (en[k]) begin
        t_q[k] <= t_q[k-1];
      end
    end
    for (int k = 3; k <= 8; k++) begin
      if (en[k]) begin
        wsum_q[k] <= wsum_q[k-1];
      end
    end
    if (en[8]) begin
      p4_q <= p4_d;
    end
    if (en[9]) begin
      colour_q <= total_d[7:2];
    end
  end

  assign in_stall_o  = !en[1];
  assign out_valid_o = v_q[NUM_STAGES];
  assign colour_o    = colour_q;

`ifndef SYNTH
  // input is held off only when every stage is occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled with a bubble in the pipeline");

  // finished root leaves a remainder no larger than twice the root
  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[7] |-> ({1'b0, sqrt_q[7].rem} <= {8'b0, sqrt_q[7].root, 1'b0}))
    else $error("square root remainder out of range");

  // a stage with a word that cannot advance keeps its valid bit
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[8] && !en[8]) |=> v_q[8])
    else $error("stalled word dropped from stage 8");
`endif

endmodule

[bench/plasma_pixel_colour_top_tb.sv]
// Testbench for plasma_pixel_colour_top: directed and random pixels with random
// idling on both channels, checked word by word against a local colour model.
// Depends on ppc_pkg and plasma_pixel_colour_top.

// Holds the colours still owed by the block and checks each returned word.
class colour_board;
  logic [5:0]  owed_q[$];
  int unsigned failures;
  int unsigned checked;
  int unsigned outside;

  function new();
    failures = 0;
    checked  = 0;
    outside  = 0;
  endfunction

  // Triangle wave over one 8-bit turn, clamped to 0..255.
  function automatic int tri_level(logic [7:0] k);
    int ki;
    int s;
    ki = int'(k);
    if (ki < 64) s = 128 + ki * 2;
    else if (ki < 128) s = 128 + (128 - ki) * 2;
    else if (ki < 192) s = 128 - (ki - 128) * 2;
    else s = 128 - (256 - ki) * 2;
    if (s > 255) s = 255;
    if (s < 0) s = 0;
    return s;
  endfunction

  // Smallest r with r*r >= d.
  function automatic int root_ceil(int d);
    int r;
    r = 0;
    while (r * r < d) r++;
    return r;
  endfunction

  function automatic logic [5:0] predict_colour(logic [5:0] col, logic [4:0] row,
                                                logic [7:0] t);
    int         dx;
    int         dy;
    int         rad;
    logic [7:0] p1;
    logic [7:0] p2;
    logic [7:0] p3;
    logic [7:0] p4;
    int         sum;
    dx  = int'(col) - int'(ppc_pkg::WIDTH_DEF / 2);
    dy  = int'(row) - int'(ppc_pkg::HEIGHT_DEF / 2);
    rad = (root_ceil(dx * dx + dy * dy) * 6) & 255;
    p1  = 8'((int'(col) * 6 + int'(t)) & 255);
    p2  = 8'((int'(row) * 8 + int'(t) * 2) & 255);
    p3  = 8'(((int'(col) + int'(row)) * 4 + int'(t)) & 255);
    p4  = 8'((rad + int'(t)) & 255);
    sum = (tri_level(p1) >> 2) + (tri_level(p2) >> 2)
        + (tri_level(p3) >> 2) + (tri_level(p4) >> 2);
    return 6'((sum >> 2) & 63);
  endfunction

  function void note_pixel(logic [5:0] col, logic [4:0] row, logic [7:0] t);
    if (col >= ppc_pkg::WIDTH_DEF || row >= ppc_pkg::HEIGHT_DEF) outside++;
    owed_q.push_back(predict_colour(col, row, t));
  endfunction

  function void check_colour(logic [5:0] got);
    logic [5:0] want;
    if (owed_q.size() == 0) begin
      if (failures < 10) $display("ERROR: colour %0d returned with none owed", got);
      failures++;
      return;
    end
    want = owed_q.pop_front();
    checked++;
    if (got !== want) begin
      if (failures < 10)
        $display("ERROR: word %0d colour expected %0d got %0d", checked, want, got);
      failures++;
    end
  endfunction

  function int unsigned pending();
    return owed_q.size();
  endfunction
endclass

module plasma_pixel_colour_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // All block inputs start at known values; reset is held from time zero.
  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [5:0] column_i     = '0;
  logic [4:0] row_i        = '0;
  logic [7:0] frame_time_i = '0;
  logic       out_stall_i  = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [5:0] colour_o;

  colour_board sb = new();

  // When low, both sides run flat out: no input gaps, no output stalls.
  bit          idle_on = 1'b1;
  int unsigned hold_left = 0;
  int unsigned directed_cnt = 0;

  plasma_pixel_colour_top #(
    .WIDTH  (ppc_pkg::WIDTH_DEF),
    .HEIGHT (ppc_pkg::HEIGHT_DEF)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .column_i     (column_i),
    .row_i        (row_i),
    .frame_time_i (frame_time_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .colour_o     (colour_o)
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Receiver: takes a word on valid && !stall, then picks the next stall
  // state. Everything reads pre-edge values, drives with NBAs only.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_colour(colour_o);
    if (!idle_on) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else if (hold_left != 0) begin
      hold_left--;
    end else if (out_stall_i) begin
      // release, and stay free while a random hold runs down before the next stall
      out_stall_i <= 1'b0;
      hold_left = $urandom_range(0, 5);
    end else begin
      hold_left = idle_length();
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end
    end
  end

  // Sender: optional gap, then hold the word until an edge takes it.
  // Back-to-back words just overwrite the payload; valid stays high.
  task automatic send_pixel(input logic [5:0] col, input logic [4:0] row,
                            input logic [7:0] t);
    int unsigned gap;
    gap = idle_on ? idle_length() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    column_i     <= col;
    row_i        <= row;
    frame_time_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(col, row, t);
  endtask

  // Corners, the raw field maxima, the centre (zero distance), wave peak and
  // trough hit by each phase, pixels just outside the plasma, and
  // alternating bit patterns.
  task automatic run_directed();
    send_pixel(6'd0,  5'd0,  8'd0);
    send_pixel(6'd39, 5'd29, 8'd255);
    send_pixel(6'd63, 5'd31, 8'd255);
    send_pixel(6'd63, 5'd0,  8'd0);
    send_pixel(6'd0,  5'd31, 8'd128);
    send_pixel(6'd20, 5'd15, 8'd0);
    send_pixel(6'd0,  5'd0,  8'd64);   // column phase at peak
    send_pixel(6'd0,  5'd0,  8'd192);  // column phase at trough
    send_pixel(6'd0,  5'd8,  8'd0);    // row phase at peak
    send_pixel(6'd0,  5'd24, 8'd0);    // row phase at trough
    send_pixel(6'd20, 5'd15, 8'd64);   // radial phase at peak
    send_pixel(6'd20, 5'd15, 8'd192);  // radial phase at trough
    send_pixel(6'd8,  5'd8,  8'd0);    // diagonal phase at peak
    send_pixel(6'd40, 5'd30, 8'd17);
    send_pixel(6'd40, 5'd0,  8'd200);
    send_pixel(6'd0,  5'd30, 8'd99);
    send_pixel(6'd63, 5'd31, 8'd0);
    send_pixel(6'd42, 5'd21, 8'd170);
    send_pixel(6'd21, 5'd10, 8'd85);
    send_pixel(6'd1,  5'd1,  8'd1);
    send_pixel(6'd39, 5'd0,  8'd255);
    send_pixel(6'd0,  5'd29, 8'd127);
    directed_cnt = 22;
  endtask

  // Random pixels, mostly inside the plasma, some over the full field range.
  // A middle stretch runs with no idling on either side.
  task automatic run_random(input int unsigned count);
    logic [5:0]  col;
    logic [4:0]  row;
    logic [7:0]  t;
    int unsigned n;
    for (n = 0; n < count; n++) begin
      idle_on = !(n >= 400 && n < 550);
      if ($urandom_range(0, 99) < 15) begin
        col = 6'($urandom_range(0, 63));
        row = 5'($urandom_range(0, 31));
      end else begin
        col = 6'($urandom_range(0, ppc_pkg::WIDTH_DEF - 1));
        row = 5'($urandom_range(0, ppc_pkg::HEIGHT_DEF - 1));
      end
      t = 8'($urandom_range(0, 255));
      send_pixel(col, row, t);
    end
  endtask

  initial begin
    int unsigned waited;
    int unsigned errors;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(1150);
    in_valid_i <= 1'b0;

    // Drain: all owed colours back, then a quiet wait with the input idle
    // to catch any stray word.
    waited = 0;
    while (sb.pending() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (ppc_pkg::NUM_STAGES + 4) @(posedge clk_i);

    errors = sb.failures;
    if (sb.pending() != 0) begin
      $display("ERROR: %0d colours never returned", sb.pending());
      errors += sb.pending();
    end

    $display("Run covered %0d directed and %0d random pixels, %0d outside the plasma;",
             directed_cnt, sb.checked + sb.pending() - directed_cnt, sb.outside);
    $display("%0d colours compared, %0d failures, with random gaps and stalls",
             sb.checked, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("ERROR: run timed out");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
design/ppc_pkg.sv
design/plasma_pixel_colour_top.sv
bench/plasma_pixel_colour_top_tb.sv
